// ===== sv/dwmf_pkg.sv =====
// Shared types, reset values and direction tables of the directional weighted
// median filter. No dependencies.
package dwmf_pkg;

  localparam int MaxWidthDef = 2048;
  localparam int QDepth      = 4;
  localparam int WinSize     = 25;
  localparam int CentreIdx   = 12;

  localparam logic [10:0] ThresholdRst = 11'd510;
  localparam logic [11:0] WidthRst     = 12'd640;
  localparam logic [11:0] HeightRst    = 12'd480;

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegWidth     = 2'd1;
  localparam logic [1:0] RegHeight    = 2'd2;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_in;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       was_replaced;
    logic       end_of_frame;
  } out_t;

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_PREP, B_RAD, B_SQRT, B_NEXT, B_DECIDE, B_RANK, B_PICK, B_DONE
  } back_state_t;

  // window index (row-major 5x5) of point i of direction k
  function automatic logic [4:0] dir_idx(input int k, input int i);
    logic [4:0] tbl [16];
    tbl = '{5'd0, 5'd6, 5'd18, 5'd24,
            5'd10, 5'd11, 5'd13, 5'd14,
            5'd20, 5'd16, 5'd8, 5'd4,
            5'd2, 5'd7, 5'd17, 5'd22};
    return tbl[k*4 + i];
  endfunction

endpackage

// ===== sv/directional_weighted_median_filter_unit.sv =====
// Directional weighted median filter, 5x5 window with replicated borders.
// Each result passes through the back part in order: it takes the job,
// reads the line store to fill the window, then per direction runs a sum
// step, a multiply step, ten square-root steps and a compare step, then a
// decide step, a rank and a pick step when the median is taken, and the
// output register.
// Requests are taken one per cycle into a four-entry queue until it fills;
// the first pixel of a frame waits for the back part to go idle, and with
// one-pixel rows every request waits for it. No clearing pass follows reset.
module directional_weighted_median_filter_unit #(
  parameter int MAX_WIDTH = dwmf_pkg::MaxWidthDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dwmf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dwmf_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import dwmf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int JW = 12 + CW + 1;

  logic [10:0] threshold;
  logic [11:0] frame_width, frame_height;
  logic        wr, restart;
  logic [CW:0] eff_w;
  logic [11:0] eff_h;
  logic [13:0] fw_ext;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign restart = wr && (paddr[3:2] == RegWidth || paddr[3:2] == RegHeight);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= ThresholdRst;
      frame_width  <= WidthRst;
      frame_height <= HeightRst;
    end else if (wr) begin
      unique case (paddr[3:2])
        RegThreshold: threshold    <= pwdata[10:0];
        RegWidth:     frame_width  <= pwdata[11:0];
        RegHeight:    frame_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegThreshold: prdata = {21'd0, threshold};
      RegWidth:     prdata = {20'd0, frame_width};
      RegHeight:    prdata = {20'd0, frame_height};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    fw_ext = {2'b00, frame_width};
    if (fw_ext == '0) eff_w = (CW+1)'(1);
    else if (fw_ext > 14'(MAX_WIDTH)) eff_w = (CW+1)'(MAX_WIDTH);
    else eff_w = (CW+1)'(fw_ext);
    eff_h = (frame_height == '0) ? 12'd1 : frame_height;
  end

  logic          q_push, q_pop, q_full, q_empty, back_idle, frame_start;
  logic [JW-1:0] q_wdata, q_rdata;
  logic [$clog2(QDepth+1)-1:0] q_count;
  logic          st_we;
  logic [CW+2:0] st_addr;
  logic [7:0]    st_data;

  dwmf_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW), .JW(JW)) u_front (
    .clk, .rst, .restart, .eff_w, .eff_h,
    .in_valid, .in_ready, .in_data,
    .q_full, .back_quiet(back_idle && q_empty),
    .q_push, .q_wdata, .st_we, .st_addr, .st_data, .frame_start
  );

  dwmf_queue #(.DW(JW), .DEPTH(QDepth)) u_queue (
    .clk, .rst, .push(q_push), .wdata(q_wdata), .pop(q_pop), .rdata(q_rdata),
    .full(q_full), .empty(q_empty), .count(q_count)
  );

  dwmf_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW), .JW(JW)) u_back (
    .clk, .rst, .eff_w, .eff_h, .threshold,
    .st_we, .st_addr, .st_data,
    .q_empty, .q_rdata, .q_pop, .idle(back_idle),
    .out_valid, .out_ready, .out_data
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(QDepth+1))'(QDepth))
    else $error("queue count beyond depth");

  a_frame_start_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && frame_start) |-> (back_idle && q_empty))
    else $error("new frame taken while back part busy");

  a_pop_when_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== sv/dwmf_queue.sv =====
// Small request queue between the front and back parts.
// Depends on dwmf_pkg for the default depth.
module dwmf_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = dwmf_pkg::QDepth
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [DW-1:0]            wdata,
  input  logic                     pop,
  output logic [DW-1:0]            rdata,
  output logic                     full,
  output logic                     empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import dwmf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] slots [DEPTH];
  logic [AW-1:0] wptr, rptr;

  assign full  = (count == ($clog2(DEPTH+1))'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

endmodule

// ===== sv/dwmf_front.sv =====
// Front part: takes pixel and drain requests, tracks raster counters,
// writes the line store and queues output positions. Depends on dwmf_pkg.
module dwmf_front #(
  parameter int MAX_WIDTH = dwmf_pkg::MaxWidthDef,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int JW        = 12 + CW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 restart,
  input  logic [CW:0]          eff_w,
  input  logic [11:0]          eff_h,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dwmf_pkg::in_t        in_data,
  input  logic                 q_full,
  input  logic                 back_quiet,
  output logic                 q_push,
  output logic [JW-1:0]        q_wdata,
  output logic                 st_we,
  output logic [CW+2:0]        st_addr,
  output logic [7:0]           st_data,
  output logic                 frame_start
);
  import dwmf_pkg::*;

  logic [CW-1:0] in_column, out_column;
  logic [11:0]   in_row, out_row;
  logic [CW+2:0] lag;

  logic          take, acc, wrap, emit, eof, narrow;
  logic [CW:0]   col_inc;
  logic [CW-1:0] in_column_next;
  logic [11:0]   in_row_next;
  logic [CW+2:0] lag_inc, limit;

  // a new frame may overwrite rows still being read for the old one
  assign frame_start = (in_row == '0) && (in_column == '0);
  // one-pixel rows: queued jobs would let the input lap the eight-row ring
  assign narrow      = (eff_w == (CW+1)'(1));
  assign in_ready    = !q_full && !((frame_start || narrow) && !back_quiet);
  assign take        = in_valid && in_ready;

  always_comb begin
    acc            = take && (in_data.mode == MODE_PIXEL) && (in_row < eff_h);
    col_inc        = {1'b0, in_column} + 1'b1;
    wrap           = (col_inc >= eff_w);
    in_column_next = in_column;
    in_row_next    = in_row;
    if (acc) begin
      in_column_next = wrap ? '0 : col_inc[CW-1:0];
      in_row_next    = wrap ? in_row + 1'b1 : in_row;
    end
    lag_inc = lag + (CW+3)'(acc);
    limit   = {1'b0, eff_w, 1'b0} + (CW+3)'(2);
    emit    = take && ((in_row_next >= eff_h) || (acc && (lag_inc > limit)));
    eof     = (out_row == eff_h - 1'b1) && ({1'b0, out_column} == eff_w - 1'b1);
  end

  assign q_push  = emit;
  assign q_wdata = {out_row, out_column, eof};
  assign st_we   = acc;
  assign st_addr = {in_row[2:0], in_column};
  assign st_data = in_data.pixel_in;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      lag        <= '0;
    end else if (take) begin
      if (emit && eof) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
        lag        <= '0;
      end else begin
        in_column <= in_column_next;
        in_row    <= in_row_next;
        if (emit) begin
          lag <= lag_inc - 1'b1;
          if ({1'b0, out_column} + 1'b1 >= eff_w) begin
            out_column <= '0;
            out_row    <= out_row + 1'b1;
          end else begin
            out_column <= out_column + 1'b1;
          end
        end else begin
          lag <= lag_inc;
        end
      end
    end
  end

endmodule

// ===== sv/dwmf_back.sv =====
// Back part: line store, window fetch, directional sums, iterative square
// root, weighted median and output register. Depends on dwmf_pkg.
module dwmf_back #(
  parameter int MAX_WIDTH = dwmf_pkg::MaxWidthDef,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int JW        = 12 + CW + 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CW:0]     eff_w,
  input  logic [11:0]     eff_h,
  input  logic [10:0]     threshold,
  input  logic            st_we,
  input  logic [CW+2:0]   st_addr,
  input  logic [7:0]      st_data,
  input  logic            q_empty,
  input  logic [JW-1:0]   q_rdata,
  output logic            q_pop,
  output logic            idle,
  output logic            out_valid,
  input  logic            out_ready,
  output dwmf_pkg::out_t  out_data
);
  import dwmf_pkg::*;

  localparam int Depth = 8 << CW;

  logic [7:0] store [Depth];
  logic [7:0] rd_data;
  logic [CW+2:0] rd_addr;

  back_state_t state, state_next;

  logic [11:0]   job_row;
  logic [CW-1:0] job_col;
  logic          job_eof;
  logic [2:0]    ls, lt;
  logic          issued_all, rd_pend;
  logic [4:0]    rd_idx, issue_idx;
  logic [7:0]    win [WinSize];
  logic [1:0]    k;
  logic [10:0]   d_k, dmin;
  logic [9:0]    sum_k;
  logic [17:0]   sq_k;
  logic [19:0]   rad, root, bitv;
  logic [3:0]    step;
  logic [7:0]    devmin;
  logic [1:0]    lowdir;
  logic [7:0]    vals [10];
  logic [3:0]    rank [10];
  logic [3:0]    rank_c [10];
  logic [7:0]    pick_lo, pick_hi;
  logic [7:0]    res_pix;
  logic          res_rep;

  always_ff @(posedge clk) begin
    if (st_we) store[st_addr] <= st_data;
    rd_data <= store[rd_addr];
  end

  // clamped fetch address of window point (ls, lt)
  logic signed [13:0]   rr;
  logic signed [CW+2:0] cc;
  logic [11:0]          rsel;
  logic [CW-1:0]        csel;
  always_comb begin
    rr = $signed({2'b00, job_row}) + $signed({11'd0, ls}) - 14'sd2;
    cc = $signed({3'b000, job_col}) + $signed({{(CW){1'b0}}, lt}) - (CW+3)'(2);
    if (rr < 0) rsel = '0;
    else if (rr > $signed({2'b00, eff_h - 1'b1})) rsel = eff_h - 1'b1;
    else rsel = rr[11:0];
    if (cc < 0) csel = '0;
    else if (cc > $signed({2'b00, eff_w - 1'b1})) csel = CW'(eff_w - 1'b1);
    else csel = cc[CW-1:0];
    rd_addr = {rsel[2:0], csel};
  end

  // per-direction figures for direction k
  logic [7:0]  pts [4];
  logic [7:0]  ad  [4];
  logic [7:0]  centre;
  always_comb begin
    centre = win[CentreIdx];
    for (int i = 0; i < 4; i++) begin
      unique case (k)
        2'd0: pts[i] = win[dir_idx(0, i)];
        2'd1: pts[i] = win[dir_idx(1, i)];
        2'd2: pts[i] = win[dir_idx(2, i)];
        default: pts[i] = win[dir_idx(3, i)];
      endcase
      ad[i] = (pts[i] > centre) ? pts[i] - centre : centre - pts[i];
    end
  end

  logic [19:0] trial;
  assign trial = root + bitv;

  always_comb begin
    vals[0] = win[dir_idx(0, 1)];
    vals[1] = win[dir_idx(0, 2)];
    vals[2] = win[dir_idx(1, 1)];
    vals[3] = win[dir_idx(1, 2)];
    vals[4] = win[dir_idx(2, 1)];
    vals[5] = win[dir_idx(2, 2)];
    vals[6] = win[dir_idx(3, 1)];
    vals[7] = win[dir_idx(3, 2)];
    unique case (lowdir)
      2'd0: begin vals[8] = vals[0]; vals[9] = vals[1]; end
      2'd1: begin vals[8] = vals[2]; vals[9] = vals[3]; end
      2'd2: begin vals[8] = vals[4]; vals[9] = vals[5]; end
      default: begin vals[8] = vals[6]; vals[9] = vals[7]; end
    endcase
  end

  // stable rank: equal values ordered by position
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      rank_c[i] = '0;
      for (int j = 0; j < 10; j++) begin
        if ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i))) begin
          rank_c[i] = rank_c[i] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (!q_empty) state_next = B_LOAD;
      B_LOAD:   if (rd_pend && rd_idx == 5'(WinSize-1)) state_next = B_PREP;
      B_PREP:   state_next = B_RAD;
      B_RAD:    state_next = B_SQRT;
      B_SQRT:   if (step == 4'd9) state_next = B_NEXT;
      B_NEXT:   state_next = (k == 2'd3) ? B_DECIDE : B_PREP;
      B_DECIDE: state_next = (dmin <= threshold) ? B_DONE : B_RANK;
      B_RANK:   state_next = B_PICK;
      B_PICK:   state_next = B_DONE;
      B_DONE:   if (!out_valid || out_ready) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    idle  = (state == B_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        {job_row, job_col, job_eof} <= q_rdata;
        ls         <= '0;
        lt         <= '0;
        issue_idx  <= '0;
        issued_all <= 1'b0;
        rd_pend    <= 1'b0;
        k          <= '0;
        dmin       <= '1;
        devmin     <= '1;
        lowdir     <= '0;
      end
      B_LOAD: begin
        rd_pend <= !issued_all;
        rd_idx  <= issue_idx;
        if (rd_pend) win[rd_idx] <= rd_data;
        if (!issued_all) begin
          issue_idx <= issue_idx + 1'b1;
          if (issue_idx == 5'(WinSize-1)) issued_all <= 1'b1;
          if (lt == 3'd4) begin
            lt <= '0;
            ls <= ls + 1'b1;
          end else begin
            lt <= lt + 1'b1;
          end
        end
      end
      B_PREP: begin
        d_k   <= 11'(ad[0]) + 11'({ad[1], 1'b0}) + 11'({ad[2], 1'b0}) + 11'(ad[3]);
        sum_k <= 10'(pts[0]) + 10'(pts[1]) + 10'(pts[2]) + 10'(pts[3]);
        sq_k  <= 18'(pts[0]) * 18'(pts[0]) + 18'(pts[1]) * 18'(pts[1])
               + 18'(pts[2]) * 18'(pts[2]) + 18'(pts[3]) * 18'(pts[3]);
      end
      B_RAD: begin
        rad  <= {sq_k, 2'b00} - 20'(sum_k) * 20'(sum_k);
        root <= '0;
        bitv <= 20'h40000;
        step <= '0;
      end
      B_SQRT: begin
        if (rad >= trial) begin
          rad  <= rad - trial;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        step <= step + 1'b1;
      end
      B_NEXT: begin
        if (d_k < dmin) dmin <= d_k;
        if (root[9:2] < devmin) begin
          devmin <= root[9:2];
          lowdir <= k;
        end
        k <= k + 1'b1;
      end
      B_DECIDE: begin
        res_pix <= win[CentreIdx];
        res_rep <= 1'b0;
      end
      B_RANK: begin
        for (int i = 0; i < 10; i++) rank[i] <= rank_c[i];
      end
      B_PICK: begin
        res_rep <= 1'b1;
        res_pix <= 8'((9'(pick_lo) + 9'(pick_hi)) >> 1);
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.pixel_out    <= res_pix;
          out_data.was_replaced <= res_rep;
          out_data.end_of_frame <= job_eof;
        end
      end
      default: ;
    endcase
  end

  // fifth and sixth smallest of the ten values
  always_comb begin
    pick_lo = '0;
    pick_hi = '0;
    for (int i = 0; i < 10; i++) begin
      if (rank[i] == 4'd4) pick_lo = vals[i];
      if (rank[i] == 4'd5) pick_hi = vals[i];
    end
  end

endmodule

// ===== tb/directional_weighted_median_filter_unit_test.sv =====
// Self-checking testbench for directional_weighted_median_filter_unit.
// Depends on dwmf_pkg; a scoreboard class predicts every filtered pixel.
module directional_weighted_median_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dwmf_pkg::*;

  localparam int RingRows = 8;
  localparam int IdleWait = 600;
  localparam int StallLimit = 20000;

  class dwmf_scoreboard;
    byte unsigned rows [RingRows*MaxWidthDef];
    byte unsigned wnd [25];
    int unsigned in_col, in_row, out_col, out_row;
    int unsigned thr, width_reg, height_reg;
    out_t filtered [$];

    function new();
      foreach (rows[i]) rows[i] = 0;
      foreach (wnd[i]) wnd[i] = 0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      thr = ThresholdRst; width_reg = WidthRst; height_reg = HeightRst;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidthDef) return MaxWidthDef;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      return height_reg == 0 ? 1 : height_reg;
    endfunction

    function void restart();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      filtered.delete();
    endfunction

    function void configure(logic [1:0] idx, logic [31:0] val);
      case (idx)
        RegThreshold: thr = val[10:0];
        RegWidth: begin
          width_reg = val[11:0];
          restart();
        end
        RegHeight: begin
          height_reg = val[11:0];
          restart();
        end
        default: ;
      endcase
    endfunction

    function int unsigned isqrt(int unsigned v);
      int unsigned r, b;
      r = 0;
      b = 32'h4000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function byte unsigned pel(int r, int c, int unsigned w, int unsigned h);
      if (r < 0) r = 0;
      if (r > int'(h) - 1) r = int'(h) - 1;
      if (c < 0) c = 0;
      if (c > int'(w) - 1) c = int'(w) - 1;
      return rows[(r % RingRows) * MaxWidthDef + c];
    endfunction

    // point i of direction k, as row offset s and column offset t
    function void dir_pt(int k, int i, output int s, output int t);
      int ds [4][4];
      int dt [4][4];
      ds = '{'{-2, -1, 1, 2}, '{0, 0, 0, 0}, '{2, 1, -1, -2}, '{-2, -1, 1, 2}};
      dt = '{'{-2, -1, 1, 2}, '{-2, -1, 1, 2}, '{-2, -1, 1, 2}, '{0, 0, 0, 0}};
      s = ds[k][i];
      t = dt[k][i];
    endfunction

    function out_t filter(int unsigned w, int unsigned h);
      out_t o;
      int s, t, ctr, k, i, j, n, lowdir;
      int unsigned p, d, sum, sq, dev, dmin, devmin;
      byte unsigned v [10];
      byte unsigned x;
      for (s = -2; s <= 2; s++)
        for (t = -2; t <= 2; t++)
          wnd[(s+2)*5 + t+2] = pel(int'(out_row) + s, int'(out_col) + t, w, h);
      ctr = wnd[12];
      dmin = 32'hFFFF_FFFF;
      devmin = 32'hFFFF_FFFF;
      lowdir = 0;
      for (k = 0; k < 4; k++) begin
        d = 0; sum = 0; sq = 0;
        for (i = 0; i < 4; i++) begin
          dir_pt(k, i, s, t);
          p = wnd[(s+2)*5 + t+2];
          d += ((i == 1 || i == 2) ? 2 : 1) * (p > ctr ? p - ctr : ctr - p);
          sum += p;
          sq += p * p;
        end
        dev = isqrt(4 * sq - sum * sum) >> 2;
        if (d < dmin) dmin = d;
        if (dev < devmin) begin
          devmin = dev;
          lowdir = k;
        end
      end
      o.end_of_frame = 1'b0;
      if (dmin <= thr) begin
        o.pixel_out = ctr[7:0];
        o.was_replaced = 1'b0;
        return o;
      end
      n = 0;
      for (k = 0; k < 4; k++)
        for (i = 1; i <= 2; i++) begin
          dir_pt(k, i, s, t);
          v[n++] = wnd[(s+2)*5 + t+2];
          if (k == lowdir) v[n++] = wnd[(s+2)*5 + t+2];
        end
      for (i = 1; i < 10; i++) begin
        x = v[i];
        j = i - 1;
        while (j >= 0 && v[j] > x) begin
          v[j+1] = v[j];
          j--;
        end
        v[j+1] = x;
      end
      o.pixel_out = 8'((int'(v[4]) + int'(v[5])) >> 1);
      o.was_replaced = 1'b1;
      return o;
    endfunction

    function void note_request(in_t req);
      int unsigned w, h;
      bit took, emit;
      out_t o;
      w = eff_w();
      h = eff_h();
      took = 0;
      if (req.mode == MODE_PIXEL && in_row < h) begin
        rows[(in_row % RingRows) * MaxWidthDef + in_col] = req.pixel_in;
        took = 1;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end
      if (in_row >= h) emit = 1;
      else if (took) emit = ((in_row*w + in_col) - (out_row*w + out_col)) > 2*w + 2;
      else emit = 0;
      if (!emit) return;
      o = filter(w, h);
      o.end_of_frame = (out_row == h - 1 && out_col == w - 1);
      if (o.end_of_frame) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
      filtered.insert(filtered.size(), o);
    endfunction

    function string check(out_t got);
      out_t e;
      string msg;
      if (filtered.size() == 0)
        return $sformatf("unexpected pixel %0d", got.pixel_out);
      e = filtered.pop_front();
      msg = "";
      if (got.pixel_out !== e.pixel_out)
        msg = {msg, $sformatf(" pixel_out %0d/%0d", got.pixel_out, e.pixel_out)};
      if (got.was_replaced !== e.was_replaced)
        msg = {msg, $sformatf(" was_replaced %0b/%0b", got.was_replaced, e.was_replaced)};
      if (got.end_of_frame !== e.end_of_frame)
        msg = {msg, $sformatf(" end_of_frame %0b/%0b", got.end_of_frame, e.end_of_frame)};
      return msg;
    endfunction

    function int pending();
      return filtered.size();
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  directional_weighted_median_filter_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dwmf_scoreboard sb;
  int errors = 0;
  int items = 0;
  int outs_seen = 0;
  int quiet = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t:%s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) begin
        string msg;
        msg = sb.check(out_data);
        if (msg != "") report_mismatch(msg);
        outs_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: changing stall pattern, plus one long hold-off
  initial begin
    int pat, hold;
    bit held;
    pat = 0;
    hold = 0;
    held = 0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && outs_seen >= 60) begin
        held = 1;
        hold = 900;
      end
      if ($urandom_range(63) == 0) pat = $urandom_range(3);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (pat)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(1) == 0);
          2: out_ready <= ($urandom_range(3) == 0);
          default: out_ready <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  task automatic send(logic mode, logic [7:0] pix);
    in_t req;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 12);
    end
    req.mode = mode;
    req.pixel_in = pix;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items++;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.configure(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IdleWait) @(posedge clk);
  endtask

  task automatic setup(int thr, int w, int h);
    settle();
    reg_write(RegThreshold, thr);
    reg_write(RegWidth, w);
    reg_write(RegHeight, h);
  endtask

  // style 0 flat with faint noise, 1 impulse noise, 2 fully random
  function automatic logic [7:0] texture(int style, logic [7:0] base);
    int r;
    case (style)
      0: begin
        r = int'(base) + $urandom_range(8) - 4;
        return (r < 0) ? 8'd0 : (r > 255) ? 8'd255 : 8'(r);
      end
      1: begin
        if ($urandom_range(4) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
        return base;
      end
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic frame(int w, int h, int style);
    int n, tail, ew;
    logic [7:0] base;
    ew = (w == 0) ? 1 : (w > MaxWidthDef) ? MaxWidthDef : w;
    if (h == 0) h = 1;
    base = 8'($urandom);
    for (n = 0; n < ew * h; n++) begin
      if ($urandom_range(15) == 0) send(MODE_DRAIN, 8'($urandom));
      send(MODE_PIXEL, texture(style, base));
    end
    tail = (ew * h < 2*ew + 2) ? ew * h : 2*ew + 2;
    for (n = 0; n < tail; n++) begin
      // a pixel once the frame is complete counts as a drain step
      if ($urandom_range(7) == 0) send(MODE_PIXEL, 8'($urandom));
      else send(MODE_DRAIN, 8'($urandom));
    end
    if ($urandom_range(3) == 0) send(MODE_DRAIN, 8'hFF);
  endtask

  initial begin
    int thr, w, h;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, early drain, pixel past frame end
    setup(0, 3, 2);
    send(MODE_DRAIN, 8'h00);
    send(MODE_PIXEL, 8'd0);
    send(MODE_PIXEL, 8'd255);
    send(MODE_PIXEL, 8'd0);
    send(MODE_PIXEL, 8'd255);
    send(MODE_PIXEL, 8'd128);
    send(MODE_PIXEL, 8'd1);
    send(MODE_PIXEL, 8'd77);
    repeat (5) send(MODE_DRAIN, 8'hAA);
    send(MODE_DRAIN, 8'h55);
    setup(2047, 1, 1);
    send(MODE_PIXEL, 8'd200);
    send(MODE_PIXEL, 8'd3);
    setup(0, 4095, 4095);
    setup(0, 1, 4095);
    repeat (12) send(MODE_PIXEL, $urandom_range(1) ? 8'd0 : 8'd255);

    while (items < 520) begin
      case ($urandom_range(3))
        0: thr = 0;
        1: thr = 2047;
        default: thr = $urandom_range(120);
      endcase
      w = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
      h = $urandom_range(1, 6);
      setup(thr, w, h);
      frame(w, h, $urandom_range(2));
    end

    settle();
    if (errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
